[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the parser rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("never violated");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error("implication violated");
`else
`define ASSERT_NEVER(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

[rtl/hrhp_pkg.sv]
// ----------------------------------------------------------------------------
// hrhp_pkg
// types, codes and token tables of the http request header parser
// ----------------------------------------------------------------------------
package hrhp_pkg;

   localparam int MaxRequestBytes = 8192;
   localparam int QueueDepth = 4;
   localparam int PosW = 13;

   localparam logic [7:0] ChCr = 8'h0d;
   localparam logic [7:0] ChLf = 8'h0a;

   localparam logic [1:0] EV_REQUEST_LINE = 2'd0;
   localparam logic [1:0] EV_HEADER_LINE = 2'd1;
   localparam logic [1:0] EV_END_HEADERS = 2'd2;

   localparam logic [1:0] METHOD_NONE = 2'd0;
   localparam logic [1:0] METHOD_POST = 2'd3;

   localparam logic [1:0] PROTO_HTTP10 = 2'd1;
   localparam logic [1:0] PROTO_HTTP11 = 2'd2;

   localparam logic [2:0] KIND_OTHER = 3'd0;
   localparam logic [2:0] KIND_LENGTH = 3'd1;
   localparam logic [2:0] KIND_ENCODING = 3'd2;
   localparam logic [2:0] KIND_MEDIA = 3'd3;
   localparam logic [2:0] KIND_CONNECTION = 3'd4;

   typedef enum logic [2:0] {
      LS_HEAD, LS_CR1, LS_LF1, LS_CR2, LS_BODY
   } line_state_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_FEED, OP_FEED_CR, OP_FEED_CR_BYTE, OP_END_LINE, OP_END_HEADERS
   } op_type;

   typedef struct packed {
      logic            clear;
      op_type          op;
      logic [7:0]      byte_value;
      logic [PosW-1:0] pos;
   } cmd_type;

   typedef enum logic [3:0] {
      PH_METHOD, PH_BAD, PH_URI_SKIP, PH_URI, PH_PROTO_SKIP, PH_PROTO, PH_RL_DONE,
      PH_NAME, PH_SKIP, PH_REST, PH_CONN, PH_CL_WS, PH_CL_PLUS, PH_CL_MINUS,
      PH_CL_DIGITS, PH_CL_STOP
   } phase_type;

   typedef enum logic [1:0] {TBL_METHOD, TBL_PROTO, TBL_NAME, TBL_CONN} table_type;

   typedef struct packed {
      logic [1:0]  event_res;
      logic        line_error;
      logic [1:0]  method;
      logic [1:0]  protocol;
      logic        keep_alive;
      logic [30:0] body_length;
      logic [12:0] uri_offset;
      logic [13:0] uri_length;
      logic [2:0]  header_kind;
      logic [12:0] value_offset;
      logic        request_ready;
   } rsp_type;

   function automatic logic [3:0] tok_len(table_type tbl, logic [1:0] k);
      logic [3:0] l;
      l = 4'd0;
      case (tbl)
         TBL_METHOD: l = (k == 2'd0) ? 4'd4 : ((k == 2'd3) ? 4'd0 : 4'd5);
         TBL_PROTO: l = (k < 2'd2) ? 4'd8 : 4'd0;
         TBL_NAME: begin
            case (k)
               2'd0: l = 4'd14;
               2'd1: l = 4'd15;
               2'd2: l = 4'd12;
               default: l = 4'd10;
            endcase
         end
         default: l = (k == 2'd0) ? 4'd10 : ((k == 2'd1) ? 4'd5 : 4'd0);
      endcase
      return l;
   endfunction

   // strings are right-aligned, so index i of a token sits len-1-i bytes up
   function automatic logic [7:0] tok_char(table_type tbl, logic [1:0] k, logic [3:0] idx);
      logic [119:0] s;
      logic [3:0]   b;
      s = '0;
      case (tbl)
         TBL_METHOD: begin
            case (k)
               2'd0: s = "GET ";
               2'd1: s = "HEAD ";
               default: s = "POST ";
            endcase
         end
         TBL_PROTO: s = (k == 2'd0) ? "HTTP/1.1" : "HTTP/1.0";
         TBL_NAME: begin
            case (k)
               2'd0: s = {"CONTENT", "_LENGTH"};
               2'd1: s = {"ACCEPT", "_ENCODING"};
               2'd2: s = {"CONTENT", "_TYPE"};
               default: s = "CONNECTION";
            endcase
         end
         default: s = (k == 2'd0) ? "keep-alive" : "close";
      endcase
      b = tok_len(tbl, k) - 4'd1 - idx;
      return s[{b, 3'b000} +: 8];
   endfunction

endpackage

[rtl/hrhp_front.sv]
// ----------------------------------------------------------------------------
// hrhp_front
// byte numbering and cr/lf line tracking, issues parse commands
// ----------------------------------------------------------------------------
module hrhp_front
   import hrhp_pkg::*;
#(
   parameter int MAX_REQUEST_BYTES = MaxRequestBytes
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] byte_value,
   input  logic       first_of_request,
   output logic       push,
   output cmd_type    cmd
);

   localparam int PW = $clog2(MAX_REQUEST_BYTES + 1);
   localparam logic [PW-1:0] PosLimit = PW'(MAX_REQUEST_BYTES);

   line_state_type ls_ff, ls_in, ls_cur;
   logic [PW-1:0]  pos_ff, pos_in, pos_cur;
   op_type         op;

   always_comb begin
      ls_cur = first_of_request ? LS_HEAD : ls_ff;
      pos_cur = first_of_request ? '0 : pos_ff;
      ls_in = ls_cur;
      pos_in = pos_cur;
      op = OP_NONE;
      if (!(byte_value == 8'd0 || ls_cur == LS_BODY || pos_cur >= PosLimit)) begin
         pos_in = pos_cur + 1'b1;
         unique case (ls_cur)
            LS_HEAD: begin
               if (byte_value == ChCr) ls_in = LS_CR1;
               else if (byte_value == ChLf) begin
                  ls_in = LS_LF1;
                  op = OP_END_LINE;
               end else op = OP_FEED;
            end
            LS_CR1, LS_CR2: begin
               if (byte_value == ChLf) begin
                  if (ls_cur == LS_CR1) begin
                     ls_in = LS_LF1;
                     op = OP_END_LINE;
                  end else begin
                     ls_in = LS_BODY;
                     op = OP_END_HEADERS;
                  end
               end else if (byte_value == ChCr) op = OP_FEED_CR;
               else begin
                  op = OP_FEED_CR_BYTE;
                  ls_in = LS_HEAD;
               end
            end
            LS_LF1: begin
               if (byte_value == ChCr) ls_in = LS_CR2;
               else if (byte_value == ChLf) begin
                  ls_in = LS_BODY;
                  op = OP_END_HEADERS;
               end else begin
                  ls_in = LS_HEAD;
                  op = OP_FEED;
               end
            end
            default: ;
         endcase
      end
      cmd.clear = first_of_request;
      cmd.op = op;
      cmd.byte_value = byte_value;
      cmd.pos = PosW'(pos_cur);
      push = take && (first_of_request || op != OP_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ls_ff <= LS_HEAD;
         pos_ff <= '0;
      end else if (take) begin
         ls_ff <= ls_in;
         pos_ff <= pos_in;
      end
   end

endmodule

[rtl/hrhp_queue.sv]
// ----------------------------------------------------------------------------
// hrhp_queue
// short command queue between line tracking and parsing
// ----------------------------------------------------------------------------
module hrhp_queue
   import hrhp_pkg::*;
#(
   parameter int DEPTH = QueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    out_valid,
   output cmd_type out_cmd
);
`include "assert_macros.svh"

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
   localparam logic [CW-1:0] DepthCnt = CW'(DEPTH);

   cmd_type        slot_ff [DEPTH];
   logic [AW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in = push ? ((wr_ff == LastPtr) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in = pop ? ((rd_ff == LastPtr) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + CW'(push) - CW'(pop);
   end

   assign full = (cnt_ff == DepthCnt);
   assign out_valid = (cnt_ff != '0);
   assign out_cmd = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, push && full && !pop)
   `ASSERT_NEVER(a_no_underflow, clock, reset, pop && !out_valid)
   `ASSERT_IMPLIES(a_ptrs_meet, clock, reset, cnt_ff == '0 || cnt_ff == DepthCnt, wr_ff == rd_ff)

endmodule

[rtl/hrhp_back.sv]
// ----------------------------------------------------------------------------
// hrhp_back
// per-byte token matching, header decoding and result register
// ----------------------------------------------------------------------------
module hrhp_back
   import hrhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_res,
   output logic        rsp_line_error,
   output logic [1:0]  rsp_method,
   output logic [1:0]  rsp_protocol,
   output logic        rsp_keep_alive,
   output logic [30:0] rsp_body_length,
   output logic [12:0] rsp_uri_offset,
   output logic [13:0] rsp_uri_length,
   output logic [2:0]  rsp_header_kind,
   output logic [12:0] rsp_value_offset,
   output logic        rsp_request_ready
);
`include "assert_macros.svh"

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  tm;
      logic [3:0]  mi;
      logic [1:0]  method;
      logic [1:0]  protocol;
      logic        keep;
      logic [31:0] accum;
      logic [30:0] len;
      logic [1:0]  seen;
      logic [12:0] uri_start;
      logic [13:0] uri_len;
      logic [12:0] vstart;
   } ps_type;

   function automatic ps_type reset_state();
      ps_type r;
      r = '0;
      r.phase = PH_METHOD;
      r.tm = 8'h07;
      return r;
   endfunction

   function automatic ps_type match_fn(ps_type s, table_type tbl, logic [2:0] n,
                                       logic [7:0] ch);
      ps_type     r;
      logic [3:0] keep;
      r = s;
      for (int k = 0; k < 4; k++) begin
         keep[k] = s.tm[k] && (3'(k) < n) && (s.mi < tok_len(tbl, 2'(k))) &&
                   (tok_char(tbl, 2'(k), s.mi) == ch);
      end
      r.tm = {s.tm[7:4], keep};
      if (s.mi != 4'd15) r.mi = s.mi + 4'd1;
      return r;
   endfunction

   function automatic ps_type value_fn(ps_type s, logic [7:0] c);
      ps_type      r;
      logic [7:0]  lc;
      logic        dig;
      logic        ws;
      logic [35:0] n;
      r = s;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      dig = (c >= "0" && c <= "9");
      ws = (c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0b || c == 8'h0c || c == 8'h0d);
      n = {1'b0, s.accum, 3'b000} + {3'b000, s.accum, 1'b0} + {32'd0, c[3:0]};
      case (s.phase)
         PH_CONN: r = match_fn(s, TBL_CONN, 3'd2, lc);
         PH_CL_WS: begin
            if (!ws) begin
               if (c == "+") r.phase = PH_CL_PLUS;
               else if (c == "-") r.phase = PH_CL_MINUS;
               else if (dig) begin
                  r.phase = PH_CL_DIGITS;
                  r.accum = {28'd0, c[3:0]};
               end else r.phase = PH_REST;
            end
         end
         PH_CL_PLUS: begin
            if (dig) begin
               r.phase = PH_CL_DIGITS;
               r.accum = {28'd0, c[3:0]};
            end else r.phase = PH_REST;
         end
         PH_CL_MINUS: r.phase = PH_REST;
         PH_CL_DIGITS: begin
            if (!dig) r.phase = PH_CL_STOP;
            else if (!s.accum[31]) r.accum = (n > 36'h07fffffff) ? 32'h80000000 : n[31:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic ps_type feed_fn(ps_type s, logic [7:0] c, logic [12:0] p);
      ps_type     r;
      logic [7:0] u;
      logic [2:0] kind;
      r = s;
      kind = KIND_OTHER;
      u = (c == "-") ? "_" : ((c >= "a" && c <= "z") ? c - 8'd32 : c);
      case (s.phase)
         PH_METHOD: begin
            r = match_fn(s, TBL_METHOD, 3'd3, c);
            if (r.tm[2:0] == 3'd0) r.phase = PH_BAD;
            else begin
               for (int k = 0; k < 3; k++) begin
                  if (r.tm[k] && r.mi == tok_len(TBL_METHOD, 2'(k))) begin
                     r.method = 2'(k + 1);
                     r.phase = PH_URI_SKIP;
                     r.uri_start = p + 13'd1;
                     r.uri_len = '0;
                  end
               end
            end
         end
         PH_URI_SKIP: begin
            if (c == " ") r.uri_start = p + 13'd1;
            else begin
               r.uri_start = p;
               r.uri_len = 14'd1;
               r.phase = PH_URI;
            end
         end
         PH_URI: begin
            if (c == " ") r.phase = PH_PROTO_SKIP;
            else if (s.uri_len != 14'h3fff) r.uri_len = s.uri_len + 14'd1;
         end
         PH_PROTO_SKIP: begin
            if (c != " ") begin
               r.tm = 8'h03;
               r.mi = '0;
               r.phase = PH_PROTO;
               r = match_fn(r, TBL_PROTO, 3'd2, c);
            end
         end
         PH_PROTO: begin
            if (c == " ") r.phase = PH_RL_DONE;
            else if (s.mi < 4'd8) r = match_fn(s, TBL_PROTO, 3'd2, c);
         end
         PH_NAME: begin
            if (c == ":") begin
               for (int k = 3; k >= 0; k--) begin
                  if (s.tm[k] && s.mi == tok_len(TBL_NAME, 2'(k))) kind = 3'(k + 1);
               end
               r.tm = {1'b0, kind, 4'h3};
               r.mi = '0;
               r.vstart = p + 13'd1;
               r.phase = PH_SKIP;
            end else r = match_fn(s, TBL_NAME, 3'd4, u);
         end
         PH_SKIP: begin
            if (c == " " || c == 8'h09) r.vstart = p + 13'd1;
            else begin
               r.vstart = p;
               kind = s.tm[6:4];
               r.phase = (kind == KIND_LENGTH) ? PH_CL_WS :
                         ((kind == KIND_CONNECTION) ? PH_CONN : PH_REST);
               r = value_fn(r, c);
            end
         end
         default: r = value_fn(s, c);
      endcase
      return r;
   endfunction

   function automatic rsp_type make_rsp(ps_type s, logic [1:0] ev, logic err,
                                        logic [2:0] kind, logic [12:0] voff, logic ready);
      rsp_type o;
      o.event_res = ev;
      o.line_error = err;
      o.method = s.method;
      o.protocol = s.protocol;
      o.keep_alive = s.keep;
      o.body_length = s.len;
      o.uri_offset = s.uri_start;
      o.uri_length = s.uri_len;
      o.header_kind = kind;
      o.value_offset = voff;
      o.request_ready = ready;
      return o;
   endfunction

   ps_type      st_ff, st_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        has;
   logic        err;
   logic [2:0]  kind;
   logic [12:0] voff;

   assign cmd_pop = cmd_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      st_in = cmd.clear ? reset_state() : st_ff;
      rsp_in = rsp_ff;
      has = 1'b0;
      err = 1'b0;
      kind = KIND_OTHER;
      voff = '0;
      case (cmd.op)
         OP_FEED: st_in = feed_fn(st_in, cmd.byte_value, cmd.pos);
         OP_FEED_CR: st_in = feed_fn(st_in, ChCr, cmd.pos - 13'd1);
         OP_FEED_CR_BYTE: begin
            st_in = feed_fn(st_in, ChCr, cmd.pos - 13'd1);
            st_in = feed_fn(st_in, cmd.byte_value, cmd.pos);
         end
         OP_END_LINE: begin
            has = 1'b1;
            if (st_in.phase <= PH_RL_DONE) begin
               err = (st_in.phase == PH_METHOD || st_in.phase == PH_BAD);
               if ((st_in.phase == PH_PROTO || st_in.phase == PH_RL_DONE) &&
                   st_in.mi == 4'd8) begin
                  if (st_in.tm[0]) begin
                     st_in.protocol = PROTO_HTTP11;
                     st_in.keep = 1'b1;
                  end else if (st_in.tm[1]) st_in.protocol = PROTO_HTTP10;
               end
               rsp_in = make_rsp(st_in, EV_REQUEST_LINE, err, KIND_OTHER, '0, 1'b0);
            end else begin
               if (st_in.phase != PH_NAME) begin
                  kind = st_in.tm[6:4];
                  voff = st_in.vstart;
               end
               if (kind == KIND_LENGTH) begin
                  if (st_in.len != '0) kind = KIND_OTHER;
                  else if ((st_in.phase == PH_CL_DIGITS || st_in.phase == PH_CL_STOP) &&
                           !st_in.accum[31])
                     st_in.len = st_in.accum[30:0];
               end else if (kind == KIND_ENCODING) begin
                  if (st_in.seen[0]) kind = KIND_OTHER;
                  else st_in.seen[0] = 1'b1;
               end else if (kind == KIND_MEDIA) begin
                  if (st_in.seen[1]) kind = KIND_OTHER;
                  else st_in.seen[1] = 1'b1;
               end else if (kind == KIND_CONNECTION && st_in.phase == PH_CONN) begin
                  if (st_in.protocol == PROTO_HTTP10 && st_in.tm[0] && st_in.mi == 4'd10)
                     st_in.keep = 1'b1;
                  else if (st_in.protocol == PROTO_HTTP11 && st_in.tm[1] && st_in.mi == 4'd5)
                     st_in.keep = 1'b0;
               end
               rsp_in = make_rsp(st_in, EV_HEADER_LINE, 1'b0, kind, voff, 1'b0);
            end
            // next line starts fresh
            st_in.mi = '0;
            st_in.accum = '0;
            if (st_in.method == METHOD_NONE) begin
               st_in.phase = PH_METHOD;
               st_in.tm = 8'h07;
            end else begin
               st_in.phase = PH_NAME;
               st_in.tm = 8'h0f;
            end
         end
         OP_END_HEADERS: begin
            has = 1'b1;
            rsp_in = make_rsp(st_in, EV_END_HEADERS, 1'b0, KIND_OTHER, '0,
                              st_in.len == '0 && st_in.method != METHOD_POST);
         end
         default: ;
      endcase
      rsp_valid_in = cmd_pop ? has : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= reset_state();
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd_pop) st_ff <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && has) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_event_res = rsp_ff.event_res;
   assign rsp_line_error = rsp_ff.line_error;
   assign rsp_method = rsp_ff.method;
   assign rsp_protocol = rsp_ff.protocol;
   assign rsp_keep_alive = rsp_ff.keep_alive;
   assign rsp_body_length = rsp_ff.body_length;
   assign rsp_uri_offset = rsp_ff.uri_offset;
   assign rsp_uri_length = rsp_ff.uri_length;
   assign rsp_header_kind = rsp_ff.header_kind;
   assign rsp_value_offset = rsp_ff.value_offset;
   assign rsp_request_ready = rsp_ff.request_ready;

   `ASSERT_IMPLIES(a_err_on_req_line, clock, reset, rsp_valid_ff && rsp_ff.line_error, rsp_ff.event_res == EV_REQUEST_LINE)
   `ASSERT_IMPLIES(a_ready_at_end, clock, reset, rsp_valid_ff && rsp_ff.request_ready, rsp_ff.event_res == EV_END_HEADERS)
   `ASSERT_IMPLIES(a_kind_on_header, clock, reset, rsp_valid_ff && rsp_ff.header_kind != KIND_OTHER, rsp_ff.event_res == EV_HEADER_LINE)

endmodule

[rtl/http_request_header_parser_top.sv]
// result path: the command for the byte that ends a line is written into the queue, then the
//    back end registers the result; commands wait in the queue while rsp is stalled
// throughput: one request byte per cycle while the queue is not full (req_stall low)
// reset: synchronous; clears line tracking, byte position, queue and all parse state
// ----------------------------------------------------------------------------
// http_request_header_parser_top
// http/1.1 request header parser: one byte in, a result at each line end
// ----------------------------------------------------------------------------
module http_request_header_parser_top
   import hrhp_pkg::*;
#(
   parameter int MAX_REQUEST_BYTES = MaxRequestBytes,
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_first_of_request,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_res,
   output logic        rsp_line_error,
   output logic [1:0]  rsp_method,
   output logic [1:0]  rsp_protocol,
   output logic        rsp_keep_alive,
   output logic [30:0] rsp_body_length,
   output logic [12:0] rsp_uri_offset,
   output logic [13:0] rsp_uri_length,
   output logic [2:0]  rsp_header_kind,
   output logic [12:0] rsp_value_offset,
   output logic        rsp_request_ready
);

   // front end: numbers bytes, drops nul bytes, runs the cr/lf line machine
   logic    take;
   logic    push;
   cmd_type push_cmd;

   // queue to back end
   logic    q_full;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   // stall only on a full queue, never on the result side directly
   assign req_stall = q_full;
   assign take = req_valid && !q_full;

   hrhp_front #(
      .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .take            (take),
      .byte_value      (req_byte_value),
      .first_of_request(req_first_of_request),
      .push            (push),
      .cmd             (push_cmd)
   );

   hrhp_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .out_valid(q_valid),
      .out_cmd  (q_cmd)
   );

   // back end: token matching, header decode, registered result
   hrhp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (q_valid),
      .cmd               (q_cmd),
      .cmd_pop           (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_line_error    (rsp_line_error),
      .rsp_method        (rsp_method),
      .rsp_protocol      (rsp_protocol),
      .rsp_keep_alive    (rsp_keep_alive),
      .rsp_body_length   (rsp_body_length),
      .rsp_uri_offset    (rsp_uri_offset),
      .rsp_uri_length    (rsp_uri_length),
      .rsp_header_kind   (rsp_header_kind),
      .rsp_value_offset  (rsp_value_offset),
      .rsp_request_ready (rsp_request_ready)
   );

endmodule

[tb/sv/http_request_header_parser_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_header_parser_checker
// watches both channels, predicts the result of each line end and compares
// ----------------------------------------------------------------------------
module http_request_header_parser_checker
   import hrhp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_byte_value,
   input  logic        req_first_of_request,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_event_res,
   input  logic        rsp_line_error,
   input  logic [1:0]  rsp_method,
   input  logic [1:0]  rsp_protocol,
   input  logic        rsp_keep_alive,
   input  logic [30:0] rsp_body_length,
   input  logic [12:0] rsp_uri_offset,
   input  logic [13:0] rsp_uri_length,
   input  logic [2:0]  rsp_header_kind,
   input  logic [12:0] rsp_value_offset,
   input  logic        rsp_request_ready,
   output int          fail_count,
   output int          pending
);

   localparam int LengthMax = 32'h7fff_ffff;

   // parser state of the prediction
   line_state_type ln_state;
   phase_type      phase;
   int             byte_pos;
   logic [7:0]     live;
   int             tok_idx;
   logic [1:0]     cur_method;
   logic [1:0]     cur_proto;
   logic           cur_keep;
   logic [31:0]    len_acc;
   logic [30:0]    cur_length;
   logic [1:0]     seen;
   int             uri_start;
   int             uri_len;
   int             val_start;

   rsp_type        line_results[$];

   string method_tok[3] = '{"GET ", "HEAD ", "POST "};
   string proto_tok[2] = '{"HTTP/1.1", "HTTP/1.0"};
   string name_tok[4] = '{{"CONTENT", "_LENGTH"}, {"ACCEPT", "_ENCODING"},
                          {"CONTENT", "_TYPE"}, "CONNECTION"};
   string conn_tok[2] = '{"keep-alive", "close"};

   function automatic string token_of(table_type tbl, int k);
      case (tbl)
         TBL_METHOD: return method_tok[k];
         TBL_PROTO: return proto_tok[k];
         TBL_NAME: return name_tok[k];
         default: return conn_tok[k];
      endcase
   endfunction

   task automatic advance_match(table_type tbl, int n, logic [7:0] c);
      logic [3:0] keep;
      string      s;
      keep = '0;
      for (int k = 0; k < n; k++) begin
         s = token_of(tbl, k);
         if (live[k] && tok_idx < s.len() && s[tok_idx] == c) keep[k] = 1'b1;
      end
      live = {live[7:4], keep};
      if (tok_idx < 15) tok_idx++;
   endtask

   task automatic open_line();
      tok_idx = 0;
      len_acc = '0;
      if (cur_method == METHOD_NONE) begin
         phase = PH_METHOD;
         live = 8'h07;
      end else begin
         phase = PH_NAME;
         live = 8'h0f;
      end
   endtask

   task automatic clear_parse();
      ln_state = LS_HEAD;
      byte_pos = 0;
      cur_method = METHOD_NONE;
      cur_proto = '0;
      cur_keep = 1'b0;
      cur_length = '0;
      seen = '0;
      uri_start = 0;
      uri_len = 0;
      val_start = 0;
      open_line();
   endtask

   function automatic bit is_blank(logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0b || c == 8'h0c || c == 8'h0d;
   endfunction

   function automatic rsp_type make_result(logic [1:0] ev, logic err, logic [2:0] kind,
                                           int voff, logic ready);
      rsp_type r;
      r.event_res = ev;
      r.line_error = err;
      r.method = cur_method;
      r.protocol = cur_proto;
      r.keep_alive = cur_keep;
      r.body_length = cur_length;
      r.uri_offset = 13'(uri_start);
      r.uri_length = 14'(uri_len);
      r.header_kind = kind;
      r.value_offset = 13'(voff);
      r.request_ready = ready;
      return r;
   endfunction

   task automatic value_byte(logic [7:0] c);
      logic [7:0] lc;
      bit         dig;
      longint     n;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      dig = c >= "0" && c <= "9";
      case (phase)
         PH_CONN: advance_match(TBL_CONN, 2, lc);
         PH_CL_WS: begin
            if (!is_blank(c)) begin
               if (c == "+") phase = PH_CL_PLUS;
               else if (c == "-") phase = PH_CL_MINUS;
               else if (dig) begin
                  phase = PH_CL_DIGITS;
                  len_acc = 32'(c - "0");
               end else phase = PH_REST;
            end
         end
         PH_CL_PLUS: begin
            if (dig) begin
               phase = PH_CL_DIGITS;
               len_acc = 32'(c - "0");
            end else phase = PH_REST;
         end
         PH_CL_MINUS: phase = PH_REST;
         PH_CL_DIGITS: begin
            if (!dig) phase = PH_CL_STOP;
            else if (len_acc <= LengthMax) begin
               n = longint'(len_acc) * 10 + longint'(c - "0");
               len_acc = (n > LengthMax) ? 32'h8000_0000 : 32'(n);
            end
         end
         default: ;
      endcase
   endtask

   task automatic parse_byte(logic [7:0] c, int p);
      logic [2:0] kind;
      string      s;
      case (phase)
         PH_METHOD: begin
            advance_match(TBL_METHOD, 3, c);
            if (live[2:0] == 3'b000) phase = PH_BAD;
            else begin
               for (int k = 0; k < 3; k++) begin
                  s = method_tok[k];
                  if (live[k] && tok_idx == s.len()) begin
                     cur_method = 2'(k + 1);
                     phase = PH_URI_SKIP;
                     uri_start = p + 1;
                     uri_len = 0;
                  end
               end
            end
         end
         PH_URI_SKIP: begin
            if (c == " ") uri_start = p + 1;
            else begin
               uri_start = p;
               uri_len = 1;
               phase = PH_URI;
            end
         end
         PH_URI: begin
            if (c == " ") phase = PH_PROTO_SKIP;
            else if (uri_len < 16'h3fff) uri_len++;
         end
         PH_PROTO_SKIP: begin
            if (c != " ") begin
               live = 8'h03;
               tok_idx = 0;
               phase = PH_PROTO;
               advance_match(TBL_PROTO, 2, c);
            end
         end
         PH_PROTO: begin
            if (c == " ") phase = PH_RL_DONE;
            else if (tok_idx < 8) advance_match(TBL_PROTO, 2, c);
         end
         PH_NAME: begin
            if (c == ":") begin
               kind = KIND_OTHER;
               for (int k = 0; k < 4; k++) begin
                  s = name_tok[k];
                  if (kind == KIND_OTHER && live[k] && tok_idx == s.len()) kind = 3'(k + 1);
               end
               live = {1'b0, kind, 4'h3};
               tok_idx = 0;
               val_start = p + 1;
               phase = PH_SKIP;
            end else if (c == "-") advance_match(TBL_NAME, 4, "_");
            else if (c >= "a" && c <= "z") advance_match(TBL_NAME, 4, c - 8'd32);
            else advance_match(TBL_NAME, 4, c);
         end
         PH_SKIP: begin
            if (c == " " || c == 8'h09) val_start = p + 1;
            else begin
               val_start = p;
               kind = live[6:4];
               if (kind == KIND_LENGTH) phase = PH_CL_WS;
               else if (kind == KIND_CONNECTION) phase = PH_CONN;
               else phase = PH_REST;
               value_byte(c);
            end
         end
         default: value_byte(c);
      endcase
   endtask

   task automatic close_line();
      logic [2:0] kind;
      int         voff;
      logic       err;
      if (phase <= PH_RL_DONE) begin
         err = (phase == PH_METHOD || phase == PH_BAD);
         if ((phase == PH_PROTO || phase == PH_RL_DONE) && tok_idx == 8) begin
            if (live[0]) begin
               cur_proto = PROTO_HTTP11;
               cur_keep = 1'b1;
            end else if (live[1]) cur_proto = PROTO_HTTP10;
         end
         line_results.push_back(make_result(EV_REQUEST_LINE, err, KIND_OTHER, 0, 1'b0));
      end else begin
         kind = KIND_OTHER;
         voff = 0;
         if (phase != PH_NAME) begin
            kind = live[6:4];
            voff = val_start;
         end
         if (kind == KIND_LENGTH) begin
            if (cur_length != 0) kind = KIND_OTHER;
            else if ((phase == PH_CL_DIGITS || phase == PH_CL_STOP) && len_acc <= LengthMax)
               cur_length = 31'(len_acc);
         end else if (kind == KIND_ENCODING || kind == KIND_MEDIA) begin
            if (kind == KIND_ENCODING) begin
               if (seen[0]) kind = KIND_OTHER;
               else seen[0] = 1'b1;
            end else begin
               if (seen[1]) kind = KIND_OTHER;
               else seen[1] = 1'b1;
            end
         end else if (kind == KIND_CONNECTION && phase == PH_CONN) begin
            if (cur_proto == PROTO_HTTP10 && live[0] && tok_idx == 10) cur_keep = 1'b1;
            else if (cur_proto == PROTO_HTTP11 && live[1] && tok_idx == 5) cur_keep = 1'b0;
         end
         line_results.push_back(make_result(EV_HEADER_LINE, 1'b0, kind, voff, 1'b0));
      end
      open_line();
   endtask

   task automatic close_headers();
      ln_state = LS_BODY;
      line_results.push_back(make_result(EV_END_HEADERS, 1'b0, KIND_OTHER, 0,
                                         cur_length == 0 && cur_method != METHOD_POST));
   endtask

   task automatic predict_byte(logic [7:0] c, logic first);
      int p;
      if (first) clear_parse();
      if (c == 8'h00 || ln_state == LS_BODY || byte_pos >= MaxRequestBytes) return;
      p = byte_pos;
      case (ln_state)
         LS_HEAD: begin
            if (c == ChCr) ln_state = LS_CR1;
            else if (c == ChLf) begin
               ln_state = LS_LF1;
               close_line();
            end else parse_byte(c, p);
         end
         LS_CR1, LS_CR2: begin
            if (c == ChLf) begin
               if (ln_state == LS_CR1) begin
                  ln_state = LS_LF1;
                  close_line();
               end else close_headers();
            end else if (c == ChCr) parse_byte(ChCr, p - 1);
            else begin
               parse_byte(ChCr, p - 1);
               parse_byte(c, p);
               ln_state = LS_HEAD;
            end
         end
         LS_LF1: begin
            if (c == ChCr) ln_state = LS_CR2;
            else if (c == ChLf) close_headers();
            else begin
               ln_state = LS_HEAD;
               parse_byte(c, p);
            end
         end
         default: ;
      endcase
      byte_pos = p + 1;
   endtask

   task automatic report(string field, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   task automatic check_result();
      rsp_type w;
      if (line_results.size() == 0) begin
         report("unexpected result, event", rsp_event_res, -1);
         return;
      end
      w = line_results.pop_front();
      if (rsp_event_res !== w.event_res) report("event_res", rsp_event_res, w.event_res);
      if (rsp_line_error !== w.line_error) report("line_error", rsp_line_error, w.line_error);
      if (rsp_method !== w.method) report("method", rsp_method, w.method);
      if (rsp_protocol !== w.protocol) report("protocol", rsp_protocol, w.protocol);
      if (rsp_keep_alive !== w.keep_alive) report("keep_alive", rsp_keep_alive, w.keep_alive);
      if (rsp_body_length !== w.body_length)
         report("body_length", rsp_body_length, w.body_length);
      if (rsp_uri_offset !== w.uri_offset) report("uri_offset", rsp_uri_offset, w.uri_offset);
      if (rsp_uri_length !== w.uri_length) report("uri_length", rsp_uri_length, w.uri_length);
      if (rsp_header_kind !== w.header_kind)
         report("header_kind", rsp_header_kind, w.header_kind);
      if (rsp_value_offset !== w.value_offset)
         report("value_offset", rsp_value_offset, w.value_offset);
      if (rsp_request_ready !== w.request_ready)
         report("request_ready", rsp_request_ready, w.request_ready);
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      clear_parse();
   end

   always @(posedge clock) begin
      if (reset) begin
         line_results.delete();
         clear_parse();
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) predict_byte(req_byte_value, req_first_of_request);
      end
      pending <= line_results.size();
   end

endmodule

[tb/sv/tb_http_request_header_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_request_header_parser_top
// drives whole requests, well formed and broken, byte by byte into the parser
// with bursty input and a stalling receiver; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_http_request_header_parser_top;
   import hrhp_pkg::*;

   localparam int RandomBytes = 950;
   localparam int IdleLimit = 5000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_byte_value;
   logic        req_first_of_request;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_event_res;
   logic        rsp_line_error;
   logic [1:0]  rsp_method;
   logic [1:0]  rsp_protocol;
   logic        rsp_keep_alive;
   logic [30:0] rsp_body_length;
   logic [12:0] rsp_uri_offset;
   logic [13:0] rsp_uri_length;
   logic [2:0]  rsp_header_kind;
   logic [12:0] rsp_value_offset;
   logic        rsp_request_ready;

   int          fail_count;
   int          pending;
   int          bytes_sent;
   int          burst_left;
   int          idle_cycles;
   int          stall_mode;
   int          stall_timer;
   int          noise_len;
   string       noise_ch;
   bit          drained;

   // bytes of the request being built
   logic [7:0]  msg[$];

   http_request_header_parser_top dut (.*);

   http_request_header_parser_checker checker_i (.*);

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // receiver: stall pattern switches between none, light and heavy every so often
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_timer <= $urandom_range(10, 120);
      end else stall_timer <= stall_timer - 1;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // watchdog on cycles where neither channel moves
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // one request byte; holds until taken, then maybe ends the burst
   task automatic push(logic [7:0] b, logic first);
      bit took;
      req_valid <= 1'b1;
      req_byte_value <= b;
      req_first_of_request <= first;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      bytes_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 200)
                                                  : $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   endtask

   task automatic add_str(string s, bit noisy);
      for (int i = 0; i < s.len(); i++) begin
         // sprinkled nul bytes, which the parser must skip
         if (noisy && $urandom_range(0, 40) == 0) msg.push_back(8'h00);
         msg.push_back(s[i]);
      end
   endtask

   task automatic send_msg();
      for (int i = 0; i < msg.size(); i++) push(msg[i], i == 0);
      msg.delete();
   endtask

   function automatic string mix_case(string s);
      string t;
      t = s;
      for (int i = 0; i < t.len(); i++) begin
         if (t[i] >= "A" && t[i] <= "Z" && $urandom_range(0, 1)) t[i] = t[i] + 8'd32;
         else if (t[i] == "_" && $urandom_range(0, 1)) t[i] = "-";
      end
      return t;
   endfunction

   function automatic string pick(string opts[$]);
      return opts[$urandom_range(0, opts.size() - 1)];
   endfunction

   function automatic string line_end();
      case ($urandom_range(0, 9))
         0: return "\n";
         1: return "\r\r\n";
         default: return "\r\n";
      endcase
   endfunction

   function automatic string rand_token(int n);
      string pool;
      string t;
      int    j;
      pool = "/abcxyzABC0189.?=&%-_~:";
      t = "";
      for (int i = 0; i < n; i++) begin
         j = $urandom_range(0, pool.len() - 1);
         t = {t, pool.substr(j, j)};
      end
      return t;
   endfunction

   function automatic string rand_value(int kind);
      case (kind)
         0: return pick('{"0", "17", "+42", "-5", "  123", "\t9", "2147483647", "2147483648",
                          "99999999999", "12abc", "", "abc", "+", "+x", "007",
                          $sformatf("%0d", $urandom_range(0, 100000))});
         1: return pick('{"keep-alive", "Keep-Alive", "CLOSE", "close", "close ", "keep",
                          "", "upgrade", "keep-alivex"});
         default: return pick('{"text/html", "gzip, deflate", "", "  x\ry", rand_token(6)});
      endcase
   endfunction

   // a full request: request line, a few headers, blank line, a little body
   task automatic build_request();
      int    n;
      int    kind;
      string name;
      add_str(pick('{"GET ", "HEAD ", "POST ", "GET ", "POST ", "PUT ", "get ", "GE", "HEADX",
                     ""}), 1'b1);
      add_str(pick('{"", " ", "  "}), 1'b1);
      add_str(rand_token($urandom_range(0, 16)), 1'b1);
      add_str(pick('{" ", "  ", ""}), 1'b1);
      add_str(pick('{"HTTP/1.1", "HTTP/1.0", "HTTP/1.1", "HTTP/2", "HTTP/1.1x", "http/1.1",
                     "HTTP/1.0 extra", "HTTP/1.", ""}), 1'b1);
      add_str(line_end(), 1'b0);
      n = $urandom_range(0, 6);
      for (int h = 0; h < n; h++) begin
         kind = $urandom_range(0, 2);
         case ($urandom_range(0, 6))
            0, 1: begin name = {"CONTENT", "_LENGTH"}; kind = 0; end
            2: begin name = "CONNECTION"; kind = 1; end
            3: name = {"ACCEPT", "_ENCODING"};
            4: name = {"CONTENT", "_TYPE"};
            5: name = pick('{"HOST", {"CONTENT", "_LENGTHX"}, "CONTENT", "CONNECTIONS", "X"});
            default: name = rand_token($urandom_range(1, 8));
         endcase
         add_str(mix_case(name), 1'b1);
         if ($urandom_range(0, 12) != 0) add_str(":", 1'b0);
         add_str(pick('{"", " ", "\t ", "   "}), 1'b1);
         add_str(rand_value(kind), 1'b1);
         add_str(line_end(), 1'b0);
      end
      add_str(pick('{"\r\n", "\n"}), 1'b0);
      if ($urandom_range(0, 2) == 0) add_str(rand_token($urandom_range(1, 6)), 1'b0);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_byte_value = 8'h00;
      req_first_of_request = 1'b0;
      rsp_stall = 1'b0;
      bytes_sent = 0;
      burst_left = 1;
      idle_cycles = 0;
      stall_mode = 0;
      stall_timer = 0;
      drained = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests: each method, both protocols, connection override,
      // largest length, overflow, minus sign, repeated headers, stray cr, bare lf
      add_str("GET /a HTTP/1.0\r\nConnection: keep-alive\r\n\r\n", 1'b0);
      send_msg();
      add_str("POST  /upload  HTTP/1.1\r\nContent-Length: 2147483647\r\n", 1'b0);
      add_str("connection:\tCLOSE\r\ncontent-length: 5\r\n\r\n", 1'b0);
      send_msg();
      add_str("HEAD / HTTP/1.1\nContent-Length: 2147483648\nContent-Length: -3\n", 1'b0);
      add_str("Accept-Encoding: gzip\nAccept-Encoding: br\nContent-Type:\n", 1'b0);
      add_str("Content-Type: a\rb\nNoColon\n\nbody", 1'b0);
      send_msg();
      add_str("BREW /pot HTTP/1.1\r\n\r\n", 1'b0);
      send_msg();
      // every byte value, all bits of the byte field both ways
      for (int v = 0; v < 256; v++) msg.push_back(8'(v));
      send_msg();

      // random requests, with raw noise now and then
      while (bytes_sent < RandomBytes - 80) begin
         if ($urandom_range(0, 7) == 0) begin
            noise_len = $urandom_range(1, 30);
            for (int i = 0; i < noise_len; i++) begin
               noise_ch = pick('{"\r", "\n", ":", " "});
               msg.push_back(($urandom_range(0, 3) == 0) ? noise_ch[0]
                                                         : 8'($urandom_range(0, 255)));
            end
            for (int i = 0; i < msg.size(); i++) push(msg[i], $urandom_range(0, 9) == 0);
            msg.delete();
         end else begin
            build_request();
            send_msg();
         end
         // one full drain partway through
         if (!drained && bytes_sent > 700) begin
            drained = 1'b1;
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending != 0) @(posedge clock);
         end
      end

      // a short closing request
      add_str("GET /z HTTP/1.1\r\nConnection: close\r\n\r\n", 1'b0);
      send_msg();

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
